// File: rtl/qte_pkg.sv
// Shared types, widths and constants for the quaternion to Euler angle unit.
// Used by every module of the unit; depends on nothing.
`default_nettype none
package qte_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TAB_LEN          = 24;

	// Width of the CORDIC datapath and of its Q.20 angle accumulator.
	localparam int CW = 38;
	localparam int ZW = 24;
	// Width of the vector components handed to the CORDIC units.
	localparam int AW = 34;

	// Pipelined square root: result bits and register depth (input register plus one stage per bit).
	localparam int ISQ_BITS = 29;
	localparam int ISQ_LAT  = ISQ_BITS + 1;
	localparam int ISQ_RW   = 59;

	localparam int FRONT_LAT = 4;

	localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
	localparam logic signed [17:0]   PI_Q13      = 18'sd25736;
	localparam logic signed [17:0]   HALF_PI_Q13 = 18'sd12868;
	localparam logic signed [AW-1:0] ONE_Q28     = 34'sd268435456;

	localparam logic [1:0] POLE_NONE  = 2'd0;
	localparam logic [1:0] POLE_NORTH = 2'd1;
	localparam logic [1:0] POLE_SOUTH = 2'd2;

	typedef struct packed {
		logic signed [AW-1:0] yaw_y;
		logic signed [AW-1:0] yaw_x;
		logic signed [AW-1:0] roll_y;
		logic signed [AW-1:0] roll_x;
		logic signed [29:0]   sine;
		logic [1:0]           pole;
	} item_t;

	// atan(2^-i) in Q.20, rounded to nearest.
	function automatic logic signed [ZW-1:0] atan_q20(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 24'sd823550;
			1: r = 24'sd486170;
			2: r = 24'sd256879;
			3: r = 24'sd130396;
			4: r = 24'sd65451;
			5: r = 24'sd32757;
			6: r = 24'sd16383;
			7: r = 24'sd8192;
			8: r = 24'sd4096;
			9: r = 24'sd2048;
			10: r = 24'sd1024;
			11: r = 24'sd512;
			12: r = 24'sd256;
			13: r = 24'sd128;
			14: r = 24'sd64;
			15: r = 24'sd32;
			16: r = 24'sd16;
			17: r = 24'sd8;
			18: r = 24'sd4;
			19: r = 24'sd2;
			20: r = 24'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/qte_front.sv
// Front end: products, pole test, atan2 operands and the square of the pitch sine.
// Four register stages; depends on qte_pkg.
`default_nettype none
module qte_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic signed [15:0]  quat_w,
	input  wire logic signed [15:0]  quat_x,
	input  wire logic signed [15:0]  quat_y,
	input  wire logic signed [15:0]  quat_z,
	input  wire logic [13:0]         threshold,
	output logic                     valid_s4,
	output qte_pkg::item_t           item_s4,
	output logic [57:0]              sqsq_s4
);
	logic                v_s1, v_s2, v_s3;
	logic signed [15:0]  w_s1, x_s1, y_s1, z_s1;
	logic signed [15:0]  w_s2, x_s2;
	logic signed [31:0]  pxy_s2, pzw_s2, pyw_s2, pxz_s2, pyy_s2, pzz_s2;
	logic signed [31:0]  pxw_s2, pyz_s2, pxx_s2;
	qte_pkg::item_t      item_s3;
	logic [28:0]         sq_s3;

	logic signed [qte_pkg::AW-1:0] t, lim, t2, clamped;
	logic                          north, south;
	logic [28:0]                   sq;
	qte_pkg::item_t                item;

	always_comb begin
		t     = qte_pkg::AW'(pxy_s2) + qte_pkg::AW'(pzw_s2);
		lim   = $signed({6'b0, threshold, 14'b0});
		north = t > lim;
		south = t < -lim;
		t2    = t <<< 1;
		if (t2 > qte_pkg::ONE_Q28) begin
			clamped = qte_pkg::ONE_Q28;
		end else if (t2 < -qte_pkg::ONE_Q28) begin
			clamped = -qte_pkg::ONE_Q28;
		end else begin
			clamped = t2;
		end
		item.sine   = 30'(clamped);
		sq          = clamped[qte_pkg::AW-1] ? 29'(-clamped) : 29'(clamped);
		item.roll_y = (qte_pkg::AW'(pxw_s2) - qte_pkg::AW'(pyz_s2)) <<< 1;
		item.roll_x = qte_pkg::ONE_Q28 - ((qte_pkg::AW'(pxx_s2) + qte_pkg::AW'(pzz_s2)) <<< 1);
		// At a pole the yaw unit works on atan2(x, w) instead.
		if (north || south) begin
			item.yaw_y = qte_pkg::AW'(x_s2);
			item.yaw_x = qte_pkg::AW'(w_s2);
		end else begin
			item.yaw_y = (qte_pkg::AW'(pyw_s2) - qte_pkg::AW'(pxz_s2)) <<< 1;
			item.yaw_x = qte_pkg::ONE_Q28 - ((qte_pkg::AW'(pyy_s2) + qte_pkg::AW'(pzz_s2)) <<< 1);
		end
		if (north) begin
			item.pole = qte_pkg::POLE_NORTH;
		end else if (south) begin
			item.pole = qte_pkg::POLE_SOUTH;
		end else begin
			item.pole = qte_pkg::POLE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			valid_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1    <= quat_w;
			x_s1    <= quat_x;
			y_s1    <= quat_y;
			z_s1    <= quat_z;
			w_s2    <= w_s1;
			x_s2    <= x_s1;
			pxy_s2  <= x_s1 * y_s1;
			pzw_s2  <= z_s1 * w_s1;
			pyw_s2  <= y_s1 * w_s1;
			pxz_s2  <= x_s1 * z_s1;
			pyy_s2  <= y_s1 * y_s1;
			pzz_s2  <= z_s1 * z_s1;
			pxw_s2  <= x_s1 * w_s1;
			pyz_s2  <= y_s1 * z_s1;
			pxx_s2  <= x_s1 * x_s1;
			item_s3 <= item;
			sq_s3   <= sq;
			item_s4 <= item_s3;
			sqsq_s4 <= 58'(sq_s3) * 58'(sq_s3);
		end
	end
endmodule
`default_nettype wire

// File: rtl/qte_isqrt.sv
// Pipelined integer square root, rounded down, of 2^56 minus the input.
// One result bit per stage; depends on qte_pkg.
`default_nettype none
module qte_isqrt (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [57:0]               sqsq,
	output logic [qte_pkg::ISQ_BITS-1:0]   root
);
	localparam int RW = qte_pkg::ISQ_RW;
	localparam int NB = qte_pkg::ISQ_BITS;

	logic [RW-1:0] rem_s  [0:NB];
	logic [NB-1:0] root_s [0:NB];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= RW'((58'(1) << 56) - sqsq);
			root_s[0] <= '0;
		end
	end

	genvar g;
	for (g = 0; g < NB; g++) begin : g_bit
		localparam int K = NB - 1 - g;
		logic [RW-1:0] trial;
		assign trial = (RW'(root_s[g]) << (K + 1)) + (RW'(1) << (2 * K));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[g] >= trial) begin
					rem_s[g+1]  <= rem_s[g] - trial;
					root_s[g+1] <= root_s[g] | (NB'(1) << K);
				end else begin
					rem_s[g+1]  <= rem_s[g];
					root_s[g+1] <= root_s[g];
				end
			end
		end
	end

	assign root = root_s[NB];
endmodule
`default_nettype wire

// File: rtl/qte_cordic.sv
// Unrolled vectoring CORDIC: angle of (x, y) in Q.20.
// One quadrant pre-rotation stage then one stage per step; depends on qte_pkg.
`default_nettype none
module qte_cordic #(
	parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [qte_pkg::CW-1:0] vec_y,
	input  wire logic signed [qte_pkg::CW-1:0] vec_x,
	output logic signed [qte_pkg::ZW-1:0]      angle
);
	localparam int N = (STEPS > qte_pkg::TAB_LEN) ? qte_pkg::TAB_LEN : STEPS;

	logic signed [qte_pkg::CW-1:0] x_s [0:N];
	logic signed [qte_pkg::CW-1:0] y_s [0:N];
	logic signed [qte_pkg::ZW-1:0] z_s [0:N];

	always_ff @(posedge clk) begin
		if (en) begin
			if (vec_x < 0 && vec_y >= 0) begin
				x_s[0] <= vec_y;
				y_s[0] <= -vec_x;
				z_s[0] <= qte_pkg::HALF_PI_Q20;
			end else if (vec_x < 0) begin
				x_s[0] <= -vec_y;
				y_s[0] <= vec_x;
				z_s[0] <= -qte_pkg::HALF_PI_Q20;
			end else begin
				x_s[0] <= vec_x;
				y_s[0] <= vec_y;
				z_s[0] <= '0;
			end
		end
	end

	genvar i;
	for (i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				// Once the residue is exactly zero the angle is final.
				if (y_s[i] == 0) begin
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					z_s[i+1] <= z_s[i];
				end else if (!y_s[i][qte_pkg::CW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + qte_pkg::atan_q20(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - qte_pkg::atan_q20(i);
				end
			end
		end
	end

	assign angle = z_s[N];
endmodule
`default_nettype wire

// File: rtl/quaternion_to_euler_angles_unit.sv
// Quaternion to Euler angles with gimbal-lock pole handling.
// Pipeline: front end, square root, CORDIC pre-rotation and steps, then the output register.
// Throughput: one request per cycle while in_stall is low, set by the fully unrolled pipeline.
// Reset clears all valid bits and loads the pole threshold with 8176; no clearing pass.
// Depends on qte_pkg, qte_front, qte_isqrt and qte_cordic.
`default_nettype none
module quaternion_to_euler_angles_unit #(
	parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [13:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] quat_w,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [16:0]      yaw_angle,
	output logic signed [15:0]      roll_angle,
	output logic signed [14:0]      pitch_angle,
	output logic [1:0]              pole_case
);
	localparam int N  = (CORDIC_STEPS > qte_pkg::TAB_LEN) ? qte_pkg::TAB_LEN : CORDIC_STEPS;
	localparam int CL = N + 1;
	localparam int IL = qte_pkg::ISQ_LAT;

	logic [13:0]    thr_q;
	logic           en, load_out;
	logic           v_front;
	qte_pkg::item_t item_front;
	logic [57:0]    sqsq;
	logic [qte_pkg::ISQ_BITS-1:0] root;

	qte_pkg::item_t item_d [0:IL-1];
	logic           v_d    [0:IL-1];
	logic [1:0]     pole_c [0:CL-1];
	logic           v_c    [0:CL-1];

	logic signed [qte_pkg::ZW-1:0] yaw_z, roll_z, pitch_z;
	logic signed [17:0] yaw_a, roll_a, pitch_a;
	logic signed [16:0] yaw_n;
	logic signed [15:0] roll_n;
	logic signed [14:0] pitch_n;
	logic               v_last;
	logic [1:0]         pole_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 14'd8176;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// The pipeline only halts when a finished result would overwrite one still waiting.
	assign v_last    = v_c[CL-1];
	assign pole_last = pole_c[CL-1];
	assign load_out  = !out_valid || !out_stall;
	assign en        = !(v_last && !load_out);
	assign in_stall  = !en;

	qte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.quat_w    (quat_w),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.threshold (thr_q),
		.valid_s4  (v_front),
		.item_s4   (item_front),
		.sqsq_s4   (sqsq)
	);

	qte_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.sqsq (sqsq),
		.root (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < IL; i++) v_d[i] <= 1'b0;
			for (int i = 0; i < CL; i++) v_c[i] <= 1'b0;
		end else if (en) begin
			v_d[0] <= v_front;
			for (int i = 1; i < IL; i++) v_d[i] <= v_d[i-1];
			v_c[0] <= v_d[IL-1];
			for (int i = 1; i < CL; i++) v_c[i] <= v_c[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_d[0] <= item_front;
			for (int i = 1; i < IL; i++) item_d[i] <= item_d[i-1];
			pole_c[0] <= item_d[IL-1].pole;
			for (int i = 1; i < CL; i++) pole_c[i] <= pole_c[i-1];
		end
	end

	qte_cordic #(.STEPS(N)) u_yaw (
		.clk   (clk),
		.en    (en),
		.vec_y (qte_pkg::CW'(item_d[IL-1].yaw_y)),
		.vec_x (qte_pkg::CW'(item_d[IL-1].yaw_x)),
		.angle (yaw_z)
	);

	qte_cordic #(.STEPS(N)) u_roll (
		.clk   (clk),
		.en    (en),
		.vec_y (qte_pkg::CW'(item_d[IL-1].roll_y)),
		.vec_x (qte_pkg::CW'(item_d[IL-1].roll_x)),
		.angle (roll_z)
	);

	qte_cordic #(.STEPS(N)) u_pitch (
		.clk   (clk),
		.en    (en),
		.vec_y (qte_pkg::CW'(item_d[IL-1].sine)),
		.vec_x ($signed({{(qte_pkg::CW-qte_pkg::ISQ_BITS){1'b0}}, root})),
		.angle (pitch_z)
	);

	// Q.20 to Q4.13 with rounding, then limited to plus or minus pi.
	function automatic logic signed [17:0] to_q13(input logic signed [qte_pkg::ZW-1:0] z);
		logic signed [qte_pkg::ZW:0] r;
		logic signed [17:0]          q;
		r = (qte_pkg::ZW+1)'(z) + 25'sd64;
		q = 18'(r >>> 7);
		if (q > qte_pkg::PI_Q13) begin
			q = qte_pkg::PI_Q13;
		end else if (q < -qte_pkg::PI_Q13) begin
			q = -qte_pkg::PI_Q13;
		end
		return q;
	endfunction

	always_comb begin
		yaw_a   = to_q13(yaw_z);
		roll_a  = to_q13(roll_z);
		pitch_a = to_q13(pitch_z);
		case (pole_last)
			qte_pkg::POLE_NORTH: begin
				yaw_n   = 17'(yaw_a <<< 1);
				roll_n  = '0;
				pitch_n = 15'(qte_pkg::HALF_PI_Q13);
			end
			qte_pkg::POLE_SOUTH: begin
				yaw_n   = 17'(-(yaw_a <<< 1));
				roll_n  = '0;
				pitch_n = 15'(-qte_pkg::HALF_PI_Q13);
			end
			default: begin
				yaw_n  = 17'(yaw_a);
				roll_n = 16'(roll_a);
				if (pitch_a > qte_pkg::HALF_PI_Q13) begin
					pitch_n = 15'(qte_pkg::HALF_PI_Q13);
				end else if (pitch_a < -qte_pkg::HALF_PI_Q13) begin
					pitch_n = 15'(-qte_pkg::HALF_PI_Q13);
				end else begin
					pitch_n = 15'(pitch_a);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= v_last;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			yaw_angle   <= yaw_n;
			roll_angle  <= roll_n;
			pitch_angle <= pitch_n;
			pole_case   <= pole_last;
		end
	end
endmodule
`default_nettype wire
